FILE: rtl/core/rbfe_pkg.sv
// Shared types and codes for the postfix boolean fragment evaluator.
// Used by rbfe_seq and the top level; depends on nothing else.
`default_nettype none

package rbfe_pkg;

    localparam int OP_W   = 11;
    localparam int KIND_W = 3;
    localparam int OPD_W  = 8;

    // Item actions.
    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_COND  = 2'd1;
    localparam logic [1:0] ACT_EVAL  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_COND_LEN   = 2'd0;
    localparam logic [1:0] REG_FRAG_COUNT = 2'd1;
    localparam logic [1:0] REG_FRAG_EN    = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        K_END  = 3'd0,
        K_LEAF = 3'd1,
        K_REF  = 3'd2,
        K_AND  = 3'd3,
        K_OR   = 3'd4,
        K_NAND = 3'd5,
        K_NOR  = 3'd6,
        K_NOT  = 3'd7
    } op_kind_t;

    typedef enum logic [2:0] {
        E_OK    = 3'd0,
        E_UNDER = 3'd1,
        E_OVER  = 3'd2,
        E_LEFT  = 3'd3,
        E_FRAG  = 3'd4,
        E_NEST  = 3'd5,
        E_COND  = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_BIN,
        S_RET
    } rbfe_state_t;

    typedef struct packed {
        logic [6:0] cond_len;
        logic [8:0] frag_count;
        logic       frag_en;
    } rbfe_cfg_t;

    typedef struct packed {
        logic valid;
        logic value;
        err_t error;
    } rbfe_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/rpn_boolean_fragment_evaluator.sv
// Top level of the postfix boolean fragment evaluator: APB registers, request decode,
// condition bits, result register. Depends on rbfe_pkg, rbfe_ram and rbfe_seq.
//
// Each request is one of: store an op into a fragment slot, load the condition bits, or
// evaluate one op of the top-level program. Store, load and ignored requests are done
// on acceptance. A top-level leaf or NOT is accepted, then executed; a binary operator
// adds a step, because the second operand comes out of the value stack memory, whose
// read data is registered. A fragment reference additionally walks the stored ops: each
// stored op is read from the fragment memory, then executed, a binary operator adds the
// stack read step, and each fragment ends with a return step. An end request is answered
// in its accept cycle and is taken only when the result register is free or being drained.
// Neither memory has a clearing pass; fragment slots must be written before they are used.
`default_nettype none

module rpn_boolean_fragment_evaluator
    import rbfe_pkg::*;
#(
    parameter int NUM_FRAGMENTS = 256,
    parameter int FRAG_MAX_LEN  = 32,
    parameter int STACK_DEPTH   = 16,
    parameter int MAX_NEST      = 4,
    parameter int MAX_COND_BITS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_frag_index,
    input  wire logic [4:0]  s_op_position,
    input  wire logic [2:0]  s_op_kind,
    input  wire logic [7:0]  s_op_operand,
    input  wire logic [63:0] s_cond_bits,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_value,
    output logic [2:0]       m_error
);

    localparam int AW = $clog2(NUM_FRAGMENTS * FRAG_MAX_LEN);

    rbfe_cfg_t                cfg_reg;
    logic [MAX_COND_BITS-1:0] cond_reg;
    logic                     m_valid_reg;
    logic                     m_value_reg;
    err_t                     m_error_reg;

    logic            cfg_wr;
    logic            s_acc;
    logic            store_ok;
    logic            seq_idle;
    rbfe_res_t       seq_res;
    logic            op_we, op_re;
    logic [AW-1:0]   op_waddr, op_raddr;
    logic [OP_W-1:0] op_wdata, op_rdata;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cond_len   <= 7'd64;
            cfg_reg.frag_count <= '0;
            cfg_reg.frag_en    <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_COND_LEN:   cfg_reg.cond_len   <= pwdata[6:0];
                REG_FRAG_COUNT: cfg_reg.frag_count <= pwdata[8:0];
                REG_FRAG_EN:    cfg_reg.frag_en    <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COND_LEN:   prdata = {25'd0, cfg_reg.cond_len};
            REG_FRAG_COUNT: prdata = {23'd0, cfg_reg.frag_count};
            REG_FRAG_EN:    prdata = {31'd0, cfg_reg.frag_en};
            default:        prdata = '0;
        endcase
    end

    // Request side: one request at a time, and only while the result register is free or being drained.
    assign s_ready = seq_idle && (!m_valid_reg || m_ready);
    assign s_acc   = s_valid && s_ready;

    assign store_ok = (32'(s_frag_index) < NUM_FRAGMENTS)
                      && (32'(s_op_position) < FRAG_MAX_LEN);
    assign op_we    = s_acc && (s_action == ACT_STORE) && store_ok;
    assign op_waddr = AW'(s_frag_index) * AW'(FRAG_MAX_LEN) + AW'(s_op_position);
    assign op_wdata = {s_op_kind, s_op_operand};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cond_reg <= '0;
        end else if (s_acc && (s_action == ACT_COND)) begin
            cond_reg <= s_cond_bits[MAX_COND_BITS-1:0];
        end
    end

    rbfe_ram #(
        .DEPTH (NUM_FRAGMENTS * FRAG_MAX_LEN),
        .WIDTH (OP_W)
    ) u_frag_mem (
        .aclk  (aclk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata (op_wdata),
        .re    (op_re),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    rbfe_seq #(
        .NUM_FRAGMENTS (NUM_FRAGMENTS),
        .FRAG_MAX_LEN  (FRAG_MAX_LEN),
        .STACK_DEPTH   (STACK_DEPTH),
        .MAX_NEST      (MAX_NEST),
        .MAX_COND_BITS (MAX_COND_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (s_acc && (s_action == ACT_EVAL)),
        .kind_i     (op_kind_t'(s_op_kind)),
        .opd_i      (s_op_operand),
        .cfg_i      (cfg_reg),
        .cond_i     (cond_reg),
        .idle_o     (seq_idle),
        .res_o      (seq_res),
        .op_re_o    (op_re),
        .op_raddr_o (op_raddr),
        .op_rdata_i (op_rdata)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_res.valid) begin
            m_value_reg <= seq_res.value;
            m_error_reg <= seq_res.error;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_error = m_error_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rbfe_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// Holds the stored fragment ops and the value stacks; no package dependency.
`default_nettype none

module rbfe_ram #(
    parameter int DEPTH = 80,
    parameter int WIDTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rbfe_seq.sv
// Op sequencer: executes evaluate requests, walks stored fragments and keeps the stacks.
// Depends on rbfe_pkg and rbfe_ram (value stack memory); reads the fragment memory outside.
`default_nettype none

module rbfe_seq
    import rbfe_pkg::*;
#(
    parameter int NUM_FRAGMENTS = 256,
    parameter int FRAG_MAX_LEN  = 32,
    parameter int STACK_DEPTH   = 16,
    parameter int MAX_NEST      = 4,
    parameter int MAX_COND_BITS = 64,
    localparam int AW = $clog2(NUM_FRAGMENTS * FRAG_MAX_LEN)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start_i,
    input  wire op_kind_t                 kind_i,
    input  wire logic [OPD_W-1:0]         opd_i,
    input  wire rbfe_cfg_t                cfg_i,
    input  wire logic [MAX_COND_BITS-1:0] cond_i,
    output logic                          idle_o,
    output rbfe_res_t                     res_o,
    output logic                          op_re_o,
    output logic [AW-1:0]                 op_raddr_o,
    input  wire logic [OP_W-1:0]          op_rdata_i
);

    localparam int SD_TOT = (MAX_NEST + 1) * STACK_DEPTH;
    localparam int SAW    = $clog2(SD_TOT);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int LW     = $clog2(MAX_NEST + 1);
    localparam int FW     = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int PW     = $clog2(FRAG_MAX_LEN);
    localparam logic [PW-1:0] POS_LAST = PW'(FRAG_MAX_LEN - 1);

    rbfe_state_t     state_reg, state_next;
    logic [LW-1:0]   level_reg, level_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic            tos_reg, tos_next;
    logic [SAW-1:0]  sbase_reg, sbase_next;
    logic [AW-1:0]   fbase_reg, fbase_next;
    logic [PW-1:0]   pos_reg, pos_next;
    op_kind_t        kind_reg, kind_next;
    logic [OPD_W-1:0] opd_reg, opd_next;
    err_t            err_reg, err_next;

    // Return frames: the caller's fragment base, op position and stack count.
    logic [AW-1:0]   frm_fbase_reg [MAX_NEST];
    logic [PW-1:0]   frm_pos_reg   [MAX_NEST];
    logic [SPW-1:0]  frm_sp_reg    [MAX_NEST];
    logic            frm_we;
    logic [FW-1:0]   frm_widx, frm_ridx;

    op_kind_t        cur_kind;
    logic [OPD_W-1:0] cur_opd;
    logic            bad_cond, bad_frag, nest_full, st_full;
    logic [MAX_COND_BITS-1:0] cond_sh;
    logic            leaf_bit, bin_a, bin_r;

    logic            st_we, st_re, st_rdata;
    logic [SAW-1:0]  st_waddr, st_raddr;

    logic            push, push_val, op_done, abort;
    err_t            abort_code;

    rbfe_ram #(
        .DEPTH (SD_TOT),
        .WIDTH (1)
    ) u_stack (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (tos_reg),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Inside a fragment the op comes from the fragment memory, at top level from the request.
    assign cur_kind = (level_reg == '0) ? kind_reg : op_kind_t'(op_rdata_i[OP_W-1:OPD_W]);
    assign cur_opd  = (level_reg == '0) ? opd_reg : op_rdata_i[OPD_W-1:0];

    assign cond_sh   = cond_i >> cur_opd;
    assign leaf_bit  = cond_sh[0];
    assign bad_cond  = (cur_opd >= {1'b0, cfg_i.cond_len}) || (32'(cur_opd) >= MAX_COND_BITS);
    assign bad_frag  = !cfg_i.frag_en || ({1'b0, cur_opd} >= cfg_i.frag_count)
                       || (32'(cur_opd) >= NUM_FRAGMENTS);
    assign nest_full = level_reg >= LW'(MAX_NEST);
    assign st_full   = sp_reg >= SPW'(STACK_DEPTH);

    assign st_waddr  = sbase_reg + SAW'(sp_reg) - 1'b1;
    assign st_raddr  = sbase_reg + SAW'(sp_reg) - SAW'(2);
    assign frm_widx  = FW'(level_reg);
    assign frm_ridx  = FW'(level_reg - 1'b1);

    assign bin_a = st_rdata;
    always_comb begin
        case (cur_kind)
            K_AND:   bin_r = bin_a & tos_reg;
            K_OR:    bin_r = bin_a | tos_reg;
            K_NAND:  bin_r = ~(bin_a & tos_reg);
            default: bin_r = ~(bin_a | tos_reg);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        sp_next    = sp_reg;
        tos_next   = tos_reg;
        sbase_next = sbase_reg;
        fbase_next = fbase_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        opd_next   = opd_reg;
        err_next   = err_reg;
        frm_we     = 1'b0;
        st_we      = 1'b0;
        st_re      = 1'b0;
        op_re_o    = 1'b0;
        op_raddr_o = fbase_reg + AW'(pos_reg);
        res_o      = '{valid: 1'b0, value: 1'b0, error: E_OK};
        push       = 1'b0;
        push_val   = 1'b0;
        op_done    = 1'b0;
        abort      = 1'b0;
        abort_code = E_OK;

        case (state_reg)
            S_IDLE: begin
                if (start_i) begin
                    if (kind_i == K_END) begin
                        res_o.valid = 1'b1;
                        if (err_reg != E_OK) begin
                            res_o.error = err_reg;
                        end else if (sp_reg != SPW'(1)) begin
                            res_o.error = E_LEFT;
                        end else begin
                            res_o.value = tos_reg;
                        end
                        sp_next  = '0;
                        err_next = E_OK;
                    end else if (err_reg == E_OK) begin
                        kind_next  = kind_i;
                        opd_next   = opd_i;
                        state_next = S_EXEC;
                    end
                end
            end
            S_FETCH: begin
                op_re_o    = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                case (cur_kind)
                    K_END: begin
                        state_next = S_RET;
                    end
                    K_LEAF: begin
                        if (bad_cond) begin
                            abort      = 1'b1;
                            abort_code = E_COND;
                        end else begin
                            push     = 1'b1;
                            push_val = leaf_bit;
                        end
                    end
                    K_REF: begin
                        if (bad_frag) begin
                            abort      = 1'b1;
                            abort_code = E_FRAG;
                        end else if (nest_full) begin
                            abort      = 1'b1;
                            abort_code = E_NEST;
                        end else if (st_full) begin
                            abort      = 1'b1;
                            abort_code = E_OVER;
                        end else begin
                            // Spill the caller's top value now; its push slot is reserved.
                            st_we      = sp_reg != '0;
                            frm_we     = 1'b1;
                            level_next = level_reg + 1'b1;
                            sbase_next = sbase_reg + SAW'(STACK_DEPTH);
                            sp_next    = '0;
                            fbase_next = AW'(cur_opd) * AW'(FRAG_MAX_LEN);
                            pos_next   = '0;
                            state_next = S_FETCH;
                        end
                    end
                    K_NOT: begin
                        if (sp_reg == '0) begin
                            abort      = 1'b1;
                            abort_code = E_UNDER;
                        end else begin
                            tos_next = ~tos_reg;
                            op_done  = 1'b1;
                        end
                    end
                    default: begin
                        if (sp_reg < SPW'(2)) begin
                            abort      = 1'b1;
                            abort_code = E_UNDER;
                        end else begin
                            st_re      = 1'b1;
                            state_next = S_BIN;
                        end
                    end
                endcase
            end
            S_BIN: begin
                tos_next = bin_r;
                sp_next  = sp_reg - 1'b1;
                op_done  = 1'b1;
            end
            S_RET: begin
                if (sp_reg != SPW'(1)) begin
                    abort      = 1'b1;
                    abort_code = E_LEFT;
                end else begin
                    // The fragment's single value becomes the caller's new top.
                    level_next = level_reg - 1'b1;
                    sbase_next = sbase_reg - SAW'(STACK_DEPTH);
                    sp_next    = frm_sp_reg[frm_ridx] + 1'b1;
                    fbase_next = frm_fbase_reg[frm_ridx];
                    pos_next   = frm_pos_reg[frm_ridx];
                    op_done    = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (push) begin
            if (st_full) begin
                abort      = 1'b1;
                abort_code = E_OVER;
            end else begin
                st_we    = sp_reg != '0;
                tos_next = push_val;
                sp_next  = sp_reg + 1'b1;
                op_done  = 1'b1;
            end
        end

        if (op_done) begin
            if (level_next == '0) begin
                state_next = S_IDLE;
            end else if (pos_next == POS_LAST) begin
                state_next = S_RET;
            end else begin
                pos_next   = pos_next + 1'b1;
                state_next = S_FETCH;
            end
        end

        if (abort) begin
            err_next   = abort_code;
            level_next = '0;
            sbase_next = '0;
            state_next = S_IDLE;
        end
    end

    assign idle_o = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            level_reg <= '0;
            sp_reg    <= '0;
            sbase_reg <= '0;
            err_reg   <= E_OK;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            sp_reg    <= sp_next;
            sbase_reg <= sbase_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg   <= tos_next;
        fbase_reg <= fbase_next;
        pos_reg   <= pos_next;
        kind_reg  <= kind_next;
        opd_reg   <= opd_next;
        if (frm_we) begin
            frm_fbase_reg[frm_widx] <= fbase_reg;
            frm_pos_reg[frm_widx]   <= pos_reg;
            frm_sp_reg[frm_widx]    <= sp_reg;
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LW'(MAX_NEST))
        else $error("nesting level beyond the frame count");

    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack count beyond the stack depth");

    a_idle_top: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> (level_reg == '0 && sbase_reg == '0))
        else $error("idle while still inside a fragment");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_o.valid |=> (err_reg == E_OK && sp_reg == '0 && state_reg == S_IDLE))
        else $error("end request did not clear the program state");

    a_bin_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_BIN |-> $past(state_reg) == S_EXEC)
        else $error("binary operator step without its stack read");

endmodule

`default_nettype wire
